>>> design/cts_pkg.sv
`default_nettype none
package cts_pkg;
  localparam int MaxTasks = 8;
  localparam int QueueDepth = 16;
  localparam int TaskW = 3;
  localparam int PtrW = 4;
  localparam int FillW = 5;
  localparam logic [15:0] SleepForeverCode = 16'hFFFF;
  localparam logic [15:0] TimerMsgType = 16'd1;

  localparam logic [2:0] ActPoll = 3'd0;
  localparam logic [2:0] ActReturn = 3'd1;
  localparam logic [2:0] ActSleep = 3'd2;
  localparam logic [2:0] ActTick = 3'd3;
  localparam logic [2:0] ActSend = 3'd4;
  localparam logic [2:0] ActWake = 3'd5;

  localparam logic [1:0] KindResume = 2'd0;
  localparam logic [1:0] KindMsg = 2'd1;
  localparam logic [1:0] KindTimer = 2'd2;

  localparam logic [0:0] CfgTaskCount = 1'b0;
  localparam logic [0:0] CfgQueueCap = 1'b1;

  typedef struct packed {
    logic [15:0] countdown;
    logic timer_event;
    logic asleep;
    logic restart_pending;
    logic [15:0] wake_code;
    logic [PtrW-1:0] head;
    logic [PtrW-1:0] tail;
    logic [FillW-1:0] fill;
  } task_rec_t;

  typedef struct packed {
    logic [2:0] action;
    logic [2:0] target_task;
    logic [15:0] delay;
    logic keep_switching;
    logic [15:0] msg_kind;
    logic [15:0] short_param;
    logic [31:0] long_param;
    logic [15:0] wake_value;
  } in_word_t;

  typedef struct packed {
    logic dispatched;
    logic [2:0] task_index;
    logic [1:0] call_kind;
    logic [15:0] out_msg_kind;
    logic [15:0] out_short_param;
    logic [31:0] out_long_param;
    logic [15:0] out_wake_code;
    logic send_accepted;
  } out_word_t;
endpackage
`default_nettype wire

>>> design/cts_if.sv
`default_nettype none
interface cts_in_if;
  logic valid;
  logic ready;
  cts_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cts_out_if;
  logic valid;
  logic ready;
  cts_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/cts_task_mem.sv
`default_nettype none
module cts_task_mem import cts_pkg::*; (
  input  wire logic clk_i,
  input  wire logic [TaskW-1:0] raddr_i,
  output logic [$bits(task_rec_t)-1:0] rdata_o,
  input  wire logic we_i,
  input  wire logic [TaskW-1:0] waddr_i,
  input  wire logic [$bits(task_rec_t)-1:0] wdata_i
);
  logic [$bits(task_rec_t)-1:0] mem [MaxTasks];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

>>> design/cts_msg_mem.sv
`default_nettype none
module cts_msg_mem import cts_pkg::*; (
  input  wire logic clk_i,
  input  wire logic [TaskW+PtrW-1:0] raddr_i,
  output logic [63:0] rdata_o,
  input  wire logic we_i,
  input  wire logic [TaskW+PtrW-1:0] waddr_i,
  input  wire logic [63:0] wdata_i
);
  logic [63:0] mem [MaxTasks*QueueDepth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

>>> design/cooperative_task_scheduler.sv
`default_nettype none
// Cooperative round-robin task scheduler.
// Input channel in_if carries one word per scheduler event (poll, handler
// return, sleep, tick, send, wake); output channel out_if returns exactly one
// result word per event, in order. Config writes (cfg_we_i, cfg_idx_i,
// cfg_data_i) set task_count (index 0) and queue_capacity (index 1); the user
// must write them idle only, as the block does not enforce it. Task records
// live in a one-port-read synchronous RAM, messages in a second. Return,
// sleep, send, wake and a poll without a message go through read, wait and
// modify/write, then present the result; a poll that dequeues a message adds a
// message read. An undefined action answers straight from idle. A tick walks
// the task RAM one entry at a time, a read, wait and modify step per entry
// across the ring. One event at a time: the next word is taken only after the
// result has been delivered. Reset: after rst_ni releases, a clearing sweep
// writes every task record to its reset value; no event is accepted during it.
// When the receiver stalls the result is held in the output register and no
// further event is taken until it has been delivered.
module cooperative_task_scheduler import cts_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [0:0] cfg_idx_i,
  input  wire logic [4:0] cfg_data_i,
  cts_in_if.sink in_if,
  cts_out_if.source out_if
);
  typedef enum logic [2:0] {
    StClear, StIdle, StRead, StWait, StModify, StMsg, StOut
  } state_e;

  state_e state_q;
  logic [3:0] task_count_q;
  logic [4:0] cap_q;
  logic [TaskW-1:0] cur_q;
  logic sw_en_q;
  logic [TaskW-1:0] idx_q;
  in_word_t in_q;
  out_word_t out_q;

  logic [TaskW:0] ring;
  logic [4:0] cap_lim;
  always_comb begin
    if (task_count_q == 4'd0) ring = 4'd1;
    else if (task_count_q > 4'(MaxTasks)) ring = 4'(MaxTasks);
    else ring = task_count_q;
    cap_lim = (cap_q > 5'(QueueDepth)) ? 5'(QueueDepth) : cap_q;
  end

  logic [TaskW-1:0] t_raddr, t_waddr;
  logic t_we;
  task_rec_t t_rd, t_wd;
  logic [$bits(task_rec_t)-1:0] t_rd_raw;
  assign t_rd = task_rec_t'(t_rd_raw);

  cts_task_mem u_task_mem (
    .clk_i, .raddr_i(t_raddr), .rdata_o(t_rd_raw),
    .we_i(t_we), .waddr_i(t_waddr), .wdata_i(t_wd)
  );

  logic m_we;
  logic [TaskW+PtrW-1:0] m_raddr, m_waddr;
  logic [63:0] m_rd, m_wd;
  cts_msg_mem u_msg_mem (
    .clk_i, .raddr_i(m_raddr), .rdata_o(m_rd),
    .we_i(m_we), .waddr_i(m_waddr), .wdata_i(m_wd)
  );

  // next poll target
  logic [TaskW:0] cur_inc;
  logic [TaskW-1:0] poll_idx;
  always_comb begin
    cur_inc = {1'b0, cur_q} + 1'b1;
    if (sw_en_q) poll_idx = (cur_inc >= ring) ? '0 : cur_inc[TaskW-1:0];
    else poll_idx = ({1'b0, cur_q} >= ring) ? '0 : cur_q;
  end

  // modify step
  task_rec_t r;
  out_word_t o;
  logic sw_d_mod;
  logic msg_rd;
  always_comb begin
    r = t_rd;
    o = '0;
    sw_d_mod = sw_en_q;
    msg_rd = 1'b0;
    t_we = 1'b0;
    t_waddr = idx_q;
    m_we = 1'b0;
    m_waddr = {idx_q, t_rd.tail};
    m_wd = {in_q.msg_kind, in_q.short_param, in_q.long_param};
    m_raddr = {idx_q, t_rd.head};
    case (in_q.action)
      ActPoll: begin
        o.task_index = idx_q;
        if (r.asleep && r.timer_event) begin
          r.countdown = '0; r.timer_event = 1'b0; r.asleep = 1'b0;
        end
        if (!r.asleep && (r.fill != '0 || r.timer_event)) begin
          o.dispatched = 1'b1;
          if (r.restart_pending) begin
            r.restart_pending = 1'b0;
            if (r.fill != '0) begin
              o.call_kind = KindMsg;
              msg_rd = 1'b1;
              r.head = r.head + 1'b1;
              r.fill = r.fill - 1'b1;
            end else begin
              o.call_kind = KindTimer;
              o.out_msg_kind = TimerMsgType;
            end
          end else begin
            o.call_kind = KindResume;
            o.out_wake_code = r.wake_code;
            sw_d_mod = 1'b1;
          end
        end
      end
      ActReturn: begin
        r.restart_pending = 1'b1;
        r.countdown = (in_q.delay == '0 || in_q.delay == SleepForeverCode) ? '0 : in_q.delay;
        r.timer_event = (in_q.delay == '0);
      end
      ActSleep: begin
        r.asleep = 1'b1;
        r.wake_code = '0;
        if (in_q.delay == '0) begin
          r.timer_event = 1'b1; r.countdown = '0;
        end else if (in_q.delay == SleepForeverCode) r.countdown = '0;
        else r.countdown = in_q.delay;
        sw_d_mod = in_q.keep_switching;
      end
      ActTick: begin
        if (r.countdown != '0) begin
          r.countdown = r.countdown - 1'b1;
          if (r.countdown == '0) r.timer_event = 1'b1;
        end
      end
      ActSend: begin
        if ({1'b0, in_q.target_task} < ring && r.fill < cap_lim) begin
          m_we = 1'b1;
          r.tail = r.tail + 1'b1;
          r.fill = r.fill + 1'b1;
          o.send_accepted = 1'b1;
        end
      end
      ActWake: begin
        if ({1'b0, in_q.target_task} < ring && r.asleep && !r.timer_event) begin
          r.timer_event = 1'b1;
          r.wake_code = in_q.wake_value;
        end
      end
      default: ;
    endcase
    t_wd = r;
    if (state_q == StModify) begin
      t_we = (in_q.action == ActPoll || in_q.action == ActReturn ||
              in_q.action == ActSleep || in_q.action == ActTick ||
              in_q.action == ActSend || in_q.action == ActWake);
      if (in_q.action == ActSend && {1'b0, in_q.target_task} >= ring) t_we = 1'b0;
      if (in_q.action == ActWake && {1'b0, in_q.target_task} >= ring) t_we = 1'b0;
    end else begin
      m_we = 1'b0;
    end
    if (state_q == StClear) begin
      t_we = 1'b1;
      t_wd = '0;
      t_wd.timer_event = 1'b1;
    end
    t_raddr = idx_q;
  end

  logic in_fire;
  assign in_fire = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == StIdle);
  assign out_if.valid = (state_q == StOut);
  assign out_if.data = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      task_count_q <= 4'd1;
      cap_q <= 5'd16;
      cur_q <= '0;
      sw_en_q <= 1'b1;
      idx_q <= '0;
      in_q <= '0;
      out_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgTaskCount: task_count_q <= cfg_data_i[3:0];
          CfgQueueCap: cap_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        StClear: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == TaskW'(MaxTasks - 1)) state_q <= StIdle;
        end
        StIdle: begin
          if (in_fire) begin
            in_q <= in_if.data;
            state_q <= StRead;
            case (in_if.data.action)
              ActPoll: begin
                idx_q <= poll_idx;
                cur_q <= poll_idx;
              end
              ActReturn, ActSleep: idx_q <= cur_q;
              ActSend, ActWake: idx_q <= in_if.data.target_task;
              ActTick: idx_q <= '0;
              default: begin
                out_q <= '0;
                state_q <= StOut;
              end
            endcase
          end
        end
        StRead: state_q <= StWait;
        StWait: state_q <= StModify;
        StModify: begin
          sw_en_q <= sw_d_mod;
          if (in_q.action == ActTick) begin
            out_q <= '0;
            if ({1'b0, idx_q} + 1'b1 >= ring) state_q <= StOut;
            else begin
              idx_q <= idx_q + 1'b1;
              state_q <= StRead;
            end
          end else begin
            out_q <= o;
            state_q <= msg_rd ? StMsg : StOut;
          end
        end
        StMsg: begin
          out_q.out_msg_kind <= m_rd[63:48];
          out_q.out_short_param <= m_rd[47:32];
          out_q.out_long_param <= m_rd[31:0];
          state_q <= StOut;
        end
        StOut: if (out_if.ready) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> verif/cooperative_task_scheduler_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module cooperative_task_scheduler_tb;
  import cts_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int SettleCycles = 40;
  localparam int PhaseItems = 180;

  typedef struct {
    in_word_t w;
    bit typed;
    out_word_t res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_idx = CfgTaskCount;
  logic [4:0] cfg_data = '0;

  cts_in_if in_ch ();
  cts_out_if out_ch ();

  cooperative_task_scheduler uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we),
    .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data),
    .in_if(in_ch.sink),
    .out_if(out_ch.source)
  );

  always #2 clk_i = ~clk_i;

  // scheduler mirror
  logic [3:0] tc_reg;
  logic [4:0] cap_reg;
  int unsigned cur_task;
  bit sw_en;
  logic [15:0] cd [MaxTasks];
  bit tev [MaxTasks];
  bit slp [MaxTasks];
  bit rpend [MaxTasks];
  logic [15:0] wcode [MaxTasks];
  int unsigned qhead [MaxTasks];
  int unsigned qtail [MaxTasks];
  int unsigned qfill [MaxTasks];
  logic [63:0] mstore [MaxTasks][QueueDepth];

  out_word_t dispatch_q[$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  bit hold_off = 1'b0;
  bit use_typed = 1'b0;
  out_word_t typed_res;
  int quiet = 0;

  function automatic int unsigned ring_len();
    if (tc_reg == 0) return 1;
    if (tc_reg > MaxTasks) return MaxTasks;
    return tc_reg;
  endfunction

  function automatic int unsigned cap_len();
    if (cap_reg > QueueDepth) return QueueDepth;
    return cap_reg;
  endfunction

  function automatic void reset_sched();
    tc_reg = 4'd1;
    cap_reg = 5'd16;
    cur_task = 0;
    sw_en = 1'b1;
    for (int i = 0; i < MaxTasks; i++) begin
      cd[i] = '0; tev[i] = 1'b1; slp[i] = 1'b0; rpend[i] = 1'b0; wcode[i] = '0;
      qhead[i] = 0; qtail[i] = 0; qfill[i] = 0;
    end
  endfunction

  function automatic void set_delay(int unsigned t, logic [15:0] d);
    if (d == 0) begin
      tev[t] = 1'b1; cd[t] = '0;
    end else if (d == SleepForeverCode) begin
      cd[t] = '0; tev[t] = 1'b0;
    end else begin
      cd[t] = d; tev[t] = 1'b0;
    end
  endfunction

  function automatic out_word_t schedule_event(in_word_t w);
    out_word_t r;
    int unsigned n;
    int unsigned c;
    logic [63:0] m;
    r = '0;
    n = ring_len();
    case (w.action)
      ActPoll: begin
        if (sw_en) cur_task = (cur_task + 1 >= n) ? 0 : cur_task + 1;
        else if (cur_task >= n) cur_task = 0;
        c = cur_task;
        r.task_index = c[2:0];
        if (slp[c] && tev[c]) begin
          cd[c] = '0; tev[c] = 1'b0; slp[c] = 1'b0;
        end
        if (!slp[c] && (qfill[c] != 0 || tev[c])) begin
          r.dispatched = 1'b1;
          if (rpend[c]) begin
            rpend[c] = 1'b0;
            if (qfill[c] != 0) begin
              m = mstore[c][qhead[c]];
              r.call_kind = KindMsg;
              r.out_msg_kind = m[63:48];
              r.out_short_param = m[47:32];
              r.out_long_param = m[31:0];
              qhead[c] = (qhead[c] + 1) % QueueDepth;
              qfill[c]--;
            end else begin
              r.call_kind = KindTimer;
              r.out_msg_kind = TimerMsgType;
            end
          end else begin
            r.call_kind = KindResume;
            r.out_wake_code = wcode[c];
            sw_en = 1'b1;
          end
        end
      end
      ActReturn: begin
        rpend[cur_task] = 1'b1;
        set_delay(cur_task, w.delay);
      end
      ActSleep: begin
        c = cur_task;
        slp[c] = 1'b1;
        wcode[c] = '0;
        if (w.delay == 0) begin
          tev[c] = 1'b1; cd[c] = '0;
        end else if (w.delay == SleepForeverCode) cd[c] = '0;
        else cd[c] = w.delay;
        sw_en = w.keep_switching;
      end
      ActTick: begin
        for (int i = 0; i < n; i++) begin
          if (cd[i] != 0) begin
            cd[i]--;
            if (cd[i] == 0) tev[i] = 1'b1;
          end
        end
      end
      ActSend: begin
        if (w.target_task < n && qfill[w.target_task] < cap_len()) begin
          mstore[w.target_task][qtail[w.target_task]] =
              {w.msg_kind, w.short_param, w.long_param};
          qtail[w.target_task] = (qtail[w.target_task] + 1) % QueueDepth;
          qfill[w.target_task]++;
          r.send_accepted = 1'b1;
        end
      end
      ActWake: begin
        if (w.target_task < n && slp[w.target_task] && !tev[w.target_task]) begin
          tev[w.target_task] = 1'b1;
          wcode[w.target_task] = w.wake_value;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(string f, logic [31:0] e, logic [31:0] a);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, f, e, a);
    errors++;
  endtask

  task automatic check_dispatch(out_word_t e, out_word_t a);
    if (e.dispatched !== a.dispatched)
      report("dispatched", 32'(e.dispatched), 32'(a.dispatched));
    if (e.task_index !== a.task_index)
      report("task_index", 32'(e.task_index), 32'(a.task_index));
    if (e.call_kind !== a.call_kind)
      report("call_kind", 32'(e.call_kind), 32'(a.call_kind));
    if (e.out_msg_kind !== a.out_msg_kind)
      report("out_msg_kind", 32'(e.out_msg_kind), 32'(a.out_msg_kind));
    if (e.out_short_param !== a.out_short_param)
      report("out_short_param", 32'(e.out_short_param), 32'(a.out_short_param));
    if (e.out_long_param !== a.out_long_param)
      report("out_long_param", e.out_long_param, a.out_long_param);
    if (e.out_wake_code !== a.out_wake_code)
      report("out_wake_code", 32'(e.out_wake_code), 32'(a.out_wake_code));
    if (e.send_accepted !== a.send_accepted)
      report("send_accepted", 32'(e.send_accepted), 32'(a.send_accepted));
  endtask

  always @(posedge clk_i) begin
    out_word_t r;
    bit moved;
    moved = 1'b0;
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      r = schedule_event(in_ch.data);
      dispatch_q.push_back(use_typed ? typed_res : r);
      moved = 1'b1;
    end
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      moved = 1'b1;
      if (dispatch_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, out_ch.data);
        errors++;
      end else check_dispatch(dispatch_q.pop_front(), out_ch.data);
    end
    quiet = moved ? 0 : quiet + 1;
    if (quiet >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(negedge clk_i)
    out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle);

  task automatic send_word(in_word_t w, bit typed, out_word_t res);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    use_typed = typed;
    typed_res = res;
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (dispatch_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [4:0] val);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CfgTaskCount) tc_reg = val[3:0];
    else cap_reg = val;
  endtask

  function automatic in_word_t mk(logic [2:0] a, logic [2:0] t, logic [15:0] d,
                                  logic k, logic [15:0] mt, logic [15:0] sp,
                                  logic [31:0] lp, logic [15:0] wv);
    in_word_t w;
    w.action = a; w.target_task = t; w.delay = d; w.keep_switching = k;
    w.msg_kind = mt; w.short_param = sp; w.long_param = lp; w.wake_value = wv;
    return w;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int unsigned r;
    w = mk(ActPoll, '0, '0, 1'b1, 16'($urandom), 16'($urandom), $urandom,
           16'($urandom));
    r = $urandom_range(99);
    if (r < 25) w.action = ActPoll;
    else if (r < 40) w.action = ActReturn;
    else if (r < 50) w.action = ActSleep;
    else if (r < 65) w.action = ActTick;
    else if (r < 85) w.action = ActSend;
    else if (r < 95) w.action = ActWake;
    else w.action = 3'($urandom_range(6, 7));
    case ($urandom_range(9))
      0: w.delay = '0;
      6: w.delay = SleepForeverCode;
      7: w.delay = 16'($urandom);
      8: w.delay = 16'hFFFE;
      default: w.delay = 16'($urandom_range(1, 4));
    endcase
    w.keep_switching = ($urandom_range(9) != 0);
    w.target_task = 3'(($urandom_range(3) == 0) ? $urandom_range(7)
                                                : $urandom_range(ring_len() - 1));
    return w;
  endfunction

  initial begin
    stim_row_t rows[$];
    out_word_t z;
    int unsigned tcs[8] = '{8, 3, 1, 0, 15, 5, 8, 2};
    int unsigned caps[8] = '{16, 2, 1, 0, 31, 4, 3, 16};
    z = '0;
    reset_sched();
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    rows.push_back('{mk(ActPoll, 0, 0, 1, 0, 0, 0, 0), 1,
                     '{dispatched: 1'b1, call_kind: KindResume, default: '0}});
    rows.push_back('{mk(ActReturn, 0, 0, 1, 0, 0, 0, 0), 1, z});
    rows.push_back('{mk(ActSend, 0, 0, 0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 0), 1,
                     '{send_accepted: 1'b1, default: '0}});
    rows.push_back('{mk(ActPoll, 0, 0, 1, 0, 0, 0, 0), 1,
                     '{dispatched: 1'b1, call_kind: KindMsg, out_msg_kind: 16'hFFFF,
                       out_short_param: 16'hFFFF, out_long_param: 32'hFFFF_FFFF,
                       default: '0}});
    rows.push_back('{mk(ActReturn, 0, 0, 1, 0, 0, 0, 0), 1, z});
    rows.push_back('{mk(ActPoll, 0, 0, 1, 0, 0, 0, 0), 1,
                     '{dispatched: 1'b1, call_kind: KindTimer,
                       out_msg_kind: TimerMsgType, default: '0}});
    rows.push_back('{mk(ActSend, 1, 0, 0, 16'h1234, 1, 2, 0), 1, z});
    rows.push_back('{mk(ActWake, 7, 0, 0, 0, 0, 0, 16'hFFFF), 1, z});
    rows.push_back('{mk(3'd6, 7, 16'hFFFF, 1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                        16'hFFFF), 1, z});
    rows.push_back('{mk(3'd7, 5, 16'hAAAA, 1, 1, 1, 1, 1), 1, z});
    rows.push_back('{mk(ActReturn, 0, 3, 0, 0, 0, 0, 0), 0, z});
    rows.push_back('{mk(ActTick, 0, 0, 0, 0, 0, 0, 0), 0, z});
    rows.push_back('{mk(ActTick, 0, 0, 0, 0, 0, 0, 0), 0, z});
    rows.push_back('{mk(ActTick, 0, 0, 0, 0, 0, 0, 0), 0, z});
    rows.push_back('{mk(ActPoll, 0, 0, 0, 0, 0, 0, 0), 0, z});
    rows.push_back('{mk(ActSleep, 0, 0, 0, 0, 0, 0, 0), 0, z});
    rows.push_back('{mk(ActPoll, 0, 0, 0, 0, 0, 0, 0), 0, z});
    rows.push_back('{mk(ActSleep, 0, 16'hFFFF, 1, 0, 0, 0, 0), 0, z});
    rows.push_back('{mk(ActWake, 0, 0, 0, 0, 0, 0, 16'hFFFF), 0, z});
    rows.push_back('{mk(ActPoll, 0, 0, 0, 0, 0, 0, 0), 0, z});
    rows.push_back('{mk(ActReturn, 0, 16'hFFFF, 0, 0, 0, 0, 0), 0, z});
    rows.push_back('{mk(ActTick, 0, 0, 0, 0, 0, 0, 0), 0, z});
    rows.push_back('{mk(ActPoll, 0, 0, 0, 0, 0, 0, 0), 0, z});
    rows.push_back('{mk(ActSleep, 0, 2, 0, 0, 0, 0, 0), 0, z});
    rows.push_back('{mk(ActTick, 0, 0, 0, 0, 0, 0, 0), 0, z});
    rows.push_back('{mk(ActTick, 0, 0, 0, 0, 0, 0, 0), 0, z});
    rows.push_back('{mk(ActPoll, 0, 0, 0, 0, 0, 0, 0), 0, z});

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].res);

    for (int p = 0; p < 8; p++) begin
      drain();
      write_reg(CfgTaskCount, tcs[p][4:0]);
      write_reg(CfgQueueCap, caps[p][4:0]);
      case (p % 4)
        0: begin send_idle = 0; recv_idle = 0; end
        1: begin send_idle = 78; recv_idle = 0; end
        2: begin send_idle = 0; recv_idle = 78; end
        default: begin send_idle = 11; recv_idle = 11; end
      endcase
      if (p == 4) begin
        // long receiver stall with sender still offering
        fork
          begin
            hold_off = 1'b1;
            repeat (400) @(negedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int k = 0; k < PhaseItems; k++) begin
        if (p % 4 == 3 && k % 40 == 0) begin send_idle = 0; recv_idle = 0; end
        if (p % 4 == 3 && k % 40 == 20) begin send_idle = 11; recv_idle = 11; end
        send_word(random_word(), 1'b0, z);
      end
    end

    drain();
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire

>>> cooperative_task_scheduler.f
design/cts_pkg.sv
design/cts_if.sv
design/cts_task_mem.sv
design/cts_msg_mem.sv
design/cooperative_task_scheduler.sv
verif/cooperative_task_scheduler_tb.sv
